// ----- design/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants for the table segment morph block
// Commands, register indexes, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int VAL_W     = 24;                 // Q1.23 sample width
   localparam int W_W       = 16;                 // weight width, 32768 = 1.0
   localparam int NSEG      = 8;                  // segment slots
   localparam int CNT_VAL_W = 26;                 // segment countdown width
   localparam int DIV_NUM_W = VAL_W + 15;         // weight dividend width
   localparam int RND_HALF  = 16384;              // 0.5 in the weight scale

   localparam logic [W_W-1:0]              W_ONE  = 16'h8000;
   localparam logic signed [CNT_VAL_W-1:0] MAXPOS = 26'sd33554431;

   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_NSEG = 2'd1;
   localparam logic [1:0] CSR_TLEN = 2'd2;

   typedef enum logic [2:0] {
      CMD_LOAD_ENTRY = 3'd0,
      CMD_LOAD_DUR   = 3'd1,
      CMD_TICK       = 3'd2,
      CMD_READ       = 3'd3,
      CMD_RESTART    = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_SQR,
      ST_SQR_WAIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_ADVANCE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic [W_W-1:0]          w;
   } blend_in_type;

   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] value;
   } blend_out_type;

endpackage

// ----- design/tsm_blend.sv -----
// ----------------------------------------------------------------------------
// tsm_blend: pipelined crossfade unit
// a + round((b - a) * w / 32768), saturated to Q1.23. Three register stages,
// one operation accepted per cycle. Also used to square the weight.
// ----------------------------------------------------------------------------
module tsm_blend import tsm_pkg::*; #(
   parameter int TAG_W = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  blend_in_type       blend_in,
   input  logic [TAG_W-1:0]   in_tag,
   output blend_out_type      blend_out,
   output logic [TAG_W-1:0]   out_tag,
   output logic               busy
);

   localparam int PROD_W = VAL_W + 1 + W_W + 1;
   localparam int Q_W    = PROD_W - 15;
   localparam int SUM_W  = Q_W + 1;

   localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(8388608);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [VAL_W:0]    diff1_ff;
   logic signed [VAL_W-1:0]  a1_ff, a2_ff;
   logic [W_W-1:0]           w1_ff;
   logic [TAG_W-1:0]         tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod2_ff;
   logic signed [VAL_W-1:0]  val3_ff;

   logic signed [VAL_W:0]    diff1_in;
   logic signed [PROD_W-1:0] prod2_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [Q_W-1:0]    q;
   logic signed [SUM_W-1:0]  sum;
   logic signed [VAL_W-1:0]  val3_in;

   always_comb begin
      diff1_in = $signed({blend_in.b[VAL_W-1], blend_in.b})
               - $signed({blend_in.a[VAL_W-1], blend_in.a});
      prod2_in = diff1_ff * $signed({1'b0, w1_ff});
      rnd      = prod2_ff + PROD_W'(RND_HALF);
      // arithmetic shift: floor division by 32768
      q        = rnd[PROD_W-1:15];
      sum      = $signed({{(SUM_W-VAL_W){a2_ff[VAL_W-1]}}, a2_ff})
               + $signed({q[Q_W-1], q});
      if (sum > VMAX) begin
         val3_in = VMAX[VAL_W-1:0];
      end else if (sum < VMIN) begin
         val3_in = VMIN[VAL_W-1:0];
      end else begin
         val3_in = sum[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= blend_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      diff1_ff <= diff1_in;
      a1_ff    <= blend_in.a;
      w1_ff    <= blend_in.w;
      tag1_ff  <= in_tag;
      prod2_ff <= prod2_in;
      a2_ff    <= a1_ff;
      tag2_ff  <= tag1_ff;
      val3_ff  <= val3_in;
      tag3_ff  <= tag2_ff;
   end

   assign blend_out.valid = v3_ff;
   assign blend_out.value = val3_ff;
   assign out_tag         = tag3_ff;
   assign busy            = v1_ff | v2_ff | v3_ff;

endmodule

// ----- design/tsm_div.sv -----
// ----------------------------------------------------------------------------
// tsm_div: iterative weight divider
// Restoring division, one quotient bit per cycle. The caller
// guarantees the quotient fits 16 bits (dividend >> 16 below the divisor).
// ----------------------------------------------------------------------------
module tsm_div import tsm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [VAL_W-1:0]     den,
   output logic                 done,
   output logic [W_W-1:0]       quo
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [VAL_W-1:0]    rem_ff, rem_in;
   logic [W_W-1:0]      low_ff, low_in;
   logic [W_W-1:0]      quo_ff, quo_in;
   logic [VAL_W-1:0]    den_ff, den_in;

   logic [VAL_W:0]      trial;
   logic [VAL_W:0]      diff;
   logic                ge;

   always_comb begin
      trial   = {rem_ff, low_ff[W_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num[DIV_NUM_W-1:W_W]};
         low_in  = num[W_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         low_in = {low_ff[W_W-2:0], 1'b0};
         quo_in = {quo_ff[W_W-2:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- design/table_segment_morph.sv -----
// ----------------------------------------------------------------------------
// table_segment_morph: crossfading table sequencer
// Stores source tables and segment durations; each tick rewrites the output
// table as a crossfade between the current segment's table and the next,
// or copies the current table in the hold segment. Loads and out-of-range
// items pass through EXEC and DONE, an output read also through READ. A tick
// may divide and square the weight, then rewrites the entries and advances
// segments; one blend unit takes one entry per cycle, the divider one bit
// per cycle. Restart and reset sweep the output table, not ready.
// ----------------------------------------------------------------------------
module table_segment_morph import tsm_pkg::*; #(
   parameter int TABLE_LEN  = 512,
   parameter int NUM_TABLES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // table_select[2:0], entry_index[11:3], entry_value[35:12],
   // segment_ticks[59:36], zero[63:60]
   input  logic [63:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[23:0], active_segment[26:24], zero[31:27]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [9:0]  csr_wdata
);

   localparam int LEN_AW    = $clog2(TABLE_LEN);
   localparam int CNT_W     = $clog2(TABLE_LEN + 1);
   localparam int SRC_DEPTH = NUM_TABLES * TABLE_LEN;
   localparam int SRC_AW    = $clog2(SRC_DEPTH);
   localparam int IX_W      = (LEN_AW + 1 > 10) ? LEN_AW + 1 : 10;
   localparam int LIM_MAX   = (NUM_TABLES - 1 < NSEG - 1) ? NUM_TABLES - 1 : NSEG - 1;

   // configuration
   logic        mode_ff;
   logic [2:0]  nseg_ff;
   logic [9:0]  tlen_ff;

   // sequencer and request registers
   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [2:0]              sel_ff, sel_in;
   logic [8:0]              idx_ff, idx_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [VAL_W-1:0]        ticks_ff, ticks_in;
   logic [2:0]              cur_ff, cur_in;
   logic [2:0]              hold_ff, hold_in;
   logic [2:0]              seg_ff, seg_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic                    clr_resp_ff, clr_resp_in;
   logic                    hold_sweep_ff, hold_sweep_in;
   logic [W_W-1:0]          w_ff, w_in;
   logic [SRC_AW-1:0]       base_a_ff, base_a_in;
   logic [SRC_AW-1:0]       base_b_ff, base_b_in;
   logic signed [VAL_W-1:0] rval_ff, rval_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic [2:0]              rsp_seg_ff, rsp_seg_in;

   // segment state
   logic [VAL_W-1:0]            lengths_ff [NSEG];
   logic signed [CNT_VAL_W-1:0] counts_ff [NSEG];

   // memories
   logic signed [VAL_W-1:0] src_mem [SRC_DEPTH];
   logic signed [VAL_W-1:0] mo_mem [TABLE_LEN];
   logic signed [VAL_W-1:0] src_a_q, src_b_q, mo_q;
   logic                    src_rdv_ff;
   logic [LEN_AW-1:0]       tag_ff;

   // strobes
   logic                    accept;
   logic                    src_we, len_we, restart_go, cnt_we;
   logic                    div_start, sq_go, sweep_issue, mo_rd, clr_we, mo_we;
   logic [SRC_AW-1:0]       src_waddr, addr_a, addr_b;
   logic [LEN_AW-1:0]       mo_waddr, mo_raddr;
   logic signed [VAL_W-1:0] mo_wdata;

   // decode helpers
   logic                        sel_in_rng, idx_in_rng;
   logic [IX_W-1:0]             idx_ext, tlen_ext;
   logic [2:0]                  lim, h_c, cur_p1;
   logic                        found;
   logic [VAL_W-1:0]            d_cur;
   logic signed [CNT_VAL_W:0]   up;
   logic signed [CNT_VAL_W:0]   d_ext;
   logic [DIV_NUM_W-1:0]        div_num;
   logic signed [CNT_VAL_W-1:0] adv_nc;

   // shared units
   blend_in_type      blend_in;
   blend_out_type     blend_out;
   logic [LEN_AW-1:0] blend_tag;
   logic              blend_busy;
   logic              div_done;
   logic [W_W-1:0]    div_quo;

   assign accept = req_tvalid & req_tready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         nseg_ff <= 3'd1;
         tlen_ff <= 10'd512;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE: mode_ff <= csr_wdata[0];
            CSR_NSEG: nseg_ff <= csr_wdata[2:0];
            CSR_TLEN: tlen_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      sel_in_rng = {2'b00, sel_ff} < 5'(NUM_TABLES);
      idx_ext    = IX_W'(idx_ff);
      idx_in_rng = idx_ext < IX_W'(TABLE_LEN);
      tlen_ext   = IX_W'(tlen_ff);
      src_waddr  = SRC_AW'(sel_ff) * SRC_AW'(TABLE_LEN) + SRC_AW'(idx_ff);
      mo_raddr   = idx_ext[LEN_AW-1:0];
      cur_p1     = cur_ff + 3'd1;

      // timed segments end at the first zero duration or at the limit
      lim   = (nseg_ff > 3'(LIM_MAX)) ? 3'(LIM_MAX) : nseg_ff;
      h_c   = lim;
      found = 1'b0;
      for (int k = 0; k < NSEG - 1; k++) begin
         if (!found && 3'(k) < lim && lengths_ff[k] == '0) begin
            h_c   = 3'(k);
            found = 1'b1;
         end
      end

      d_cur   = lengths_ff[cur_ff];
      d_ext   = $signed({3'b000, d_cur});
      up      = d_ext - $signed({counts_ff[cur_ff][CNT_VAL_W-1], counts_ff[cur_ff]});
      div_num = {up[VAL_W-1:0], 15'b0} + DIV_NUM_W'(d_cur >> 1);
      adv_nc  = counts_ff[seg_ff] - CNT_VAL_W'(1);
      addr_a  = base_a_ff + SRC_AW'(pos_ff);
      addr_b  = base_b_ff + SRC_AW'(pos_ff);
   end

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sel_in        = sel_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      ticks_in      = ticks_ff;
      cur_in        = cur_ff;
      hold_in       = hold_ff;
      seg_in        = seg_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      clr_resp_in   = clr_resp_ff;
      hold_sweep_in = hold_sweep_ff;
      w_in          = w_ff;
      base_a_in     = base_a_ff;
      base_b_in     = base_b_ff;
      rval_in       = rval_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_val_in    = rsp_val_ff;
      rsp_seg_in    = rsp_seg_ff;
      req_tready    = 1'b0;
      src_we        = 1'b0;
      len_we        = 1'b0;
      restart_go    = 1'b0;
      cnt_we        = 1'b0;
      div_start     = 1'b0;
      sq_go         = 1'b0;
      sweep_issue   = 1'b0;
      mo_rd         = 1'b0;
      clr_we        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_we = 1'b1;
            if (pos_ff == CNT_W'(TABLE_LEN - 1)) begin
               pos_in   = '0;
               state_in = clr_resp_ff ? ST_DONE : ST_IDLE;
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               sel_in   = req_tdata[2:0];
               idx_in   = req_tdata[11:3];
               val_in   = req_tdata[35:12];
               ticks_in = req_tdata[59:36];
               rval_in  = '0;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_LOAD_ENTRY: src_we = sel_in_rng & idx_in_rng;
               CMD_LOAD_DUR:   len_we = 1'b1;
               CMD_TICK: begin
                  n_in      = (tlen_ext > IX_W'(TABLE_LEN)) ? CNT_W'(TABLE_LEN)
                                                            : CNT_W'(tlen_ff);
                  pos_in    = '0;
                  base_a_in = SRC_AW'(cur_ff) * SRC_AW'(TABLE_LEN);
                  state_in  = ST_SWEEP;
                  if (cur_ff >= hold_ff) begin
                     // hold segment: copy its own table
                     hold_sweep_in = 1'b1;
                     w_in          = '0;
                     base_b_in     = SRC_AW'(cur_ff) * SRC_AW'(TABLE_LEN);
                  end else begin
                     hold_sweep_in = 1'b0;
                     base_b_in     = SRC_AW'(cur_p1) * SRC_AW'(TABLE_LEN);
                     if (up <= 0 || d_cur == '0) begin
                        w_in = '0;
                     end else if (up >= d_ext) begin
                        w_in = W_ONE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
               end
               CMD_READ: begin
                  if (idx_in_rng) begin
                     mo_rd    = 1'b1;
                     state_in = ST_READ;
                  end
               end
               CMD_RESTART: begin
                  restart_go  = 1'b1;
                  cur_in      = '0;
                  hold_in     = h_c;
                  pos_in      = '0;
                  clr_resp_in = 1'b1;
                  state_in    = ST_CLEAR;
               end
               default: ;
            endcase
         end

         ST_DIV: begin
            if (div_done) begin
               w_in     = div_quo;
               state_in = mode_ff ? ST_SQR : ST_SWEEP;
            end
         end

         ST_SQR: begin
            sq_go    = 1'b1;
            state_in = ST_SQR_WAIT;
         end

         ST_SQR_WAIT: begin
            if (blend_out.valid) begin
               w_in     = blend_out.value[W_W-1:0];
               state_in = ST_SWEEP;
            end
         end

         ST_SWEEP: begin
            if (pos_ff < n_ff) begin
               sweep_issue = 1'b1;
               pos_in      = pos_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            if (!src_rdv_ff && !blend_busy) begin
               pos_in   = '0;
               seg_in   = cur_ff;
               state_in = hold_sweep_ff ? ST_DONE : ST_ADVANCE;
            end
         end

         ST_ADVANCE: begin
            // count down; step into the next segment while the count is spent
            cnt_we = 1'b1;
            if (adv_nc < 0) begin
               if (seg_ff + 3'd1 >= hold_ff) begin
                  cur_in   = seg_ff + 3'd1;
                  state_in = ST_DONE;
               end else begin
                  seg_in = seg_ff + 3'd1;
               end
            end else begin
               cur_in   = seg_ff;
               state_in = ST_DONE;
            end
         end

         ST_READ: begin
            rval_in  = mo_q;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = rval_ff;
               rsp_seg_in   = cur_ff;
               clr_resp_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cur_ff        <= '0;
         hold_ff       <= '0;
         seg_ff        <= '0;
         pos_ff        <= '0;
         n_ff          <= '0;
         clr_resp_ff   <= 1'b0;
         hold_sweep_ff <= 1'b0;
         w_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         hold_ff       <= hold_in;
         seg_ff        <= seg_in;
         pos_ff        <= pos_in;
         n_ff          <= n_in;
         clr_resp_ff   <= clr_resp_in;
         hold_sweep_ff <= hold_sweep_in;
         w_ff          <= w_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      sel_ff     <= sel_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      ticks_ff   <= ticks_in;
      base_a_ff  <= base_a_in;
      base_b_ff  <= base_b_in;
      rval_ff    <= rval_in;
      rsp_val_ff <= rsp_val_in;
      rsp_seg_ff <= rsp_seg_in;
   end

   // --------------------------------------------------------- segment state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSEG; k++) begin
            lengths_ff[k] <= '0;
            counts_ff[k]  <= MAXPOS;
         end
      end else begin
         if (len_we) begin
            lengths_ff[sel_ff] <= ticks_ff;
         end
         if (restart_go) begin
            for (int k = 0; k < NSEG; k++) begin
               counts_ff[k] <= (3'(k) < h_c) ? $signed({2'b00, lengths_ff[k]}) : MAXPOS;
            end
         end else if (cnt_we) begin
            counts_ff[seg_ff] <= adv_nc;
         end
      end
   end

   // --------------------------------------------------------- source tables
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= val_ff;
      end
      if (sweep_issue) begin
         src_a_q <= src_mem[addr_a];
         src_b_q <= src_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rdv_ff <= 1'b0;
      end else begin
         src_rdv_ff <= sweep_issue;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= pos_ff[LEN_AW-1:0];
   end

   // ----------------------------------------------------------- blend unit
   always_comb begin
      blend_in.valid = src_rdv_ff | sq_go;
      blend_in.a     = sq_go ? '0 : src_a_q;
      blend_in.b     = sq_go ? $signed({{(VAL_W-W_W){1'b0}}, w_ff})
                             : (hold_sweep_ff ? src_a_q : src_b_q);
      blend_in.w     = w_ff;
   end

   tsm_blend #(
      .TAG_W (LEN_AW)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_in  (blend_in),
      .in_tag    (tag_ff),
      .blend_out (blend_out),
      .out_tag   (blend_tag),
      .busy      (blend_busy)
   );

   tsm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (d_cur),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------------------------------------------------- output table
   always_comb begin
      mo_we    = clr_we | (blend_out.valid & (state_ff != ST_SQR_WAIT));
      mo_waddr = clr_we ? pos_ff[LEN_AW-1:0] : blend_tag;
      mo_wdata = clr_we ? '0 : blend_out.value;
   end

   always_ff @(posedge clock) begin
      if (mo_we) begin
         mo_mem[mo_waddr] <= mo_wdata;
      end
      if (mo_rd) begin
         mo_q <= mo_mem[mo_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_seg_ff, rsp_val_ff};

   // ------------------------------------------------------------ assertions
   a_cur_le_hold: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= hold_ff)
      else $error("current segment beyond hold segment");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider result outside weight phase");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      w_ff <= W_ONE)
      else $error("weight above unity");

   a_blend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      blend_out.valid |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN ||
                           state_ff == ST_SQR_WAIT))
      else $error("blend result outside sweep");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("request accepted without dispatch");

endmodule
